// ===== design/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define RAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rau assertion failed");
// Clocked check that also holds during reset.
`define RAU_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rau assertion failed during reset");
`else
`define RAU_ASSERT(lbl, clk, rst_n, prop)
`define RAU_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== design/rau_pkg.sv =====
package rau_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NEG = 3'd4,
    CMD_CMP = 3'd5
  } cmd_e;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== design/rational_arithmetic_unit.sv =====
// Rational arithmetic unit. Each input word carries two fractions a and b and a
// command in tuser; one result word leaves per input word. The unit works on one
// item at a time and takes a new word only when the previous one has moved into
// the output register. Latency depends on the command and operand values: the
// reciprocal-free paths (negate, trivial add with a or b equal to one, invalid
// command, zero denominator) are the short ones; multiply, divide and compare
// use the shared 32x32 multiplier in S_MUL0 and S_MUL1; a general add or
// subtract first runs a binary gcd of the denominators and two divisions to form
// the common denominator. With auto_reduce set, each result of an add, subtract,
// multiply, divide or negate with nonzero denominators adds a gcd of the numerator
// and denominator and two more divisions. The gcd unit takes one subtract-or-shift
// step per cycle, and each division passes through a ring of two restoring cells.
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
  input  logic [127:0] s_axis_tdata,
  // command [2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // res_num [31:0], res_den [62:32], greater [63], less [64], equal [65],
  // status [67:66], zero [71:68]
  output logic [71:0]  m_axis_tdata
);
  import rau_pkg::*;

  localparam int MW = 2 * WIDTH;
  localparam logic [MW-1:0] LIM = MW'(1) << (WIDTH - 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'h001,
    S_GCD1 = 12'h002,
    S_DIVP = 12'h004,
    S_DIVQ = 12'h008,
    S_MUL0 = 12'h010,
    S_MUL1 = 12'h020,
    S_MUL2 = 12'h040,
    S_SUM  = 12'h080,
    S_CMP  = 12'h100,
    S_RED  = 12'h200,
    S_DIVN = 12'h400,
    S_FIN  = 12'h800
  } state_e;

  function automatic logic [WIDTH-1:0] magn(input logic [WIDTH-1:0] v);
    magn = v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  state_e           state_q, state_d, entry_state;
  logic             go_q, go_d;
  logic             auto_reduce_q;
  logic             out_valid_q;
  logic [71:0]      out_data_q;
  logic             div_den_q;

  // Captured operands
  logic [2:0]       cmd_q;
  logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q, p_q, q_q;
  logic             sa_q, sb_q, zden_q;
  logic             gt_q, lt_q, eq_q;

  // Working values
  logic [MW-1:0]    num_mag_q, den_q, tb_mag_q, g_q;
  logic             num_neg_q, tb_neg_q;

  // Input decode
  logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
  logic [WIDTH-1:0] m_an, m_ad, m_bn, m_bd;
  logic [2:0]       in_cmd;
  logic             in_sa, in_sb, in_zd, in_valid_cmd, a_one, b_one, accept;

  always_comb begin
    in_an        = s_axis_tdata[WIDTH-1:0];
    in_ad        = s_axis_tdata[32+WIDTH-1:32];
    in_bn        = s_axis_tdata[64+WIDTH-1:64];
    in_bd        = s_axis_tdata[96+WIDTH-1:96];
    in_cmd       = s_axis_tuser;
    m_an         = magn(in_an);
    m_ad         = magn(in_ad);
    m_bn         = magn(in_bn);
    m_bd         = magn(in_bd);
    in_sa        = in_an[WIDTH-1] ^ in_ad[WIDTH-1];
    in_sb        = in_bn[WIDTH-1] ^ in_bd[WIDTH-1];
    in_valid_cmd = (in_cmd <= CMD_CMP);
    in_zd        = (m_ad == '0) || (in_cmd != CMD_NEG && m_bd == '0) ||
                   (in_cmd == CMD_DIV && m_bn == '0);
    a_one        = (in_an == in_ad);
    b_one        = (in_bn == in_bd);
    accept       = s_axis_tvalid && s_axis_tready;
  end

  // Pick the first state for an accepted word
  always_comb begin
    entry_state = S_FIN;
    if (in_valid_cmd && !in_zd) begin
      case (in_cmd)
        CMD_ADD, CMD_SUB:          entry_state = (a_one || b_one) ? S_SUM : S_GCD1;
        CMD_MUL, CMD_DIV, CMD_CMP: entry_state = S_MUL0;
        CMD_NEG:                   entry_state = S_RED;
        default:                   entry_state = S_FIN;
      endcase
    end
  end

  // Shared iterative units
  unit_stat_t    gcd_stat, div_stat;
  logic [MW-1:0] gcd_x, gcd_y, gcd_g, div_dvd, div_quo;
  logic          gcd_start, div_start, unit_wait, unit_done, wait_gcd, wait_div;

  always_comb begin
    wait_gcd  = (state_q == S_GCD1) || (state_q == S_RED && auto_reduce_q && go_q) ||
                (state_q == S_RED && auto_reduce_q);
    wait_div  = (state_q == S_DIVP) || (state_q == S_DIVQ) || (state_q == S_DIVN);
    unit_wait = wait_gcd || wait_div;
    gcd_start = wait_gcd && !go_q;
    div_start = wait_div && !go_q;
    unit_done = gcd_stat.done || div_stat.done;
    gcd_x     = (state_q == S_GCD1) ? MW'(ad_q) : num_mag_q;
    gcd_y     = (state_q == S_GCD1) ? MW'(bd_q) : den_q;
    case (state_q)
      S_DIVP:  div_dvd = MW'(ad_q);
      S_DIVQ:  div_dvd = MW'(bd_q);
      default: div_dvd = div_den_q ? den_q : num_mag_q;
    endcase
  end

  rau_gcd #(.MW(MW)) u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .x_i     (gcd_x),
    .y_i     (gcd_y),
    .stat_o  (gcd_stat),
    .g_o     (gcd_g)
  );

  rau_divider #(.MW(MW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (g_q),
    .stat_o  (div_stat),
    .quo_o   (div_quo)
  );

  // Shared multiplier operands
  logic [WIDTH-1:0] mul_x, mul_y;
  logic [MW-1:0]    prod;
  logic             mul1_sign;

  always_comb begin
    mul_x = an_q;
    mul_y = bd_q;
    case (state_q)
      S_MUL0: begin
        case (cmd_q)
          CMD_ADD, CMD_SUB: begin mul_x = p_q;  mul_y = bd_q; end
          CMD_MUL:          begin mul_x = ad_q; mul_y = bd_q; end
          default:          begin mul_x = bn_q; mul_y = ad_q; end
        endcase
      end
      S_MUL1: begin
        case (cmd_q)
          CMD_ADD, CMD_SUB: begin mul_x = an_q; mul_y = q_q;  end
          CMD_MUL:          begin mul_x = an_q; mul_y = bn_q; end
          default:          begin mul_x = an_q; mul_y = bd_q; end
        endcase
      end
      S_MUL2: begin
        mul_x = bn_q;
        mul_y = p_q;
      end
      default: begin
        mul_x = an_q;
        mul_y = bd_q;
      end
    endcase
    prod      = MW'(mul_x) * MW'(mul_y);
    mul1_sign = (cmd_q == CMD_MUL || cmd_q == CMD_DIV) ? (sa_q ^ sb_q) : sa_q;
  end

  // Signed sum of the two aligned terms
  logic          tb_neg_eff, sum_neg;
  logic [MW-1:0] sum_mag;

  always_comb begin
    tb_neg_eff = (cmd_q == CMD_SUB) ? ((tb_mag_q != '0) && !tb_neg_q) : tb_neg_q;
    if (num_neg_q == tb_neg_eff) begin
      sum_neg = num_neg_q;
      sum_mag = num_mag_q + tb_mag_q;
    end else if (num_mag_q >= tb_mag_q) begin
      sum_neg = num_neg_q;
      sum_mag = num_mag_q - tb_mag_q;
    end else begin
      sum_neg = tb_neg_eff;
      sum_mag = tb_mag_q - num_mag_q;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // Compare the cross products
  logic c_lneg, c_rneg, c_gt, c_lt, c_eq;

  always_comb begin
    c_lneg = num_neg_q;
    c_rneg = sb_q && (den_q != '0);
    c_gt   = 1'b0;
    c_lt   = 1'b0;
    c_eq   = 1'b0;
    if (c_lneg != c_rneg) begin
      c_gt = c_rneg;
      c_lt = c_lneg;
    end else if (num_mag_q == den_q) begin
      c_eq = 1'b1;
    end else if ((num_mag_q > den_q) != c_lneg) begin
      c_gt = 1'b1;
    end else begin
      c_lt = 1'b1;
    end
  end

  // Final range check and packing
  logic                    ovf;
  logic [MW-1:0]           tc;
  logic signed [WIDTH-1:0] tcw;
  logic [1:0]              fin_status;
  logic [71:0]             fin_data;

  always_comb begin
    ovf        = (num_neg_q ? (num_mag_q > LIM) : (num_mag_q >= LIM)) || (den_q >= LIM);
    tc         = num_neg_q ? (~num_mag_q + 1'b1) : num_mag_q;
    tcw        = tc[WIDTH-1:0];
    fin_status = zden_q ? ST_ZERO : (ovf ? ST_OVF : ST_OK);
    fin_data   = {4'b0000, fin_status, eq_q, lt_q, gt_q,
                  31'(den_q[WIDTH-2:0]), 32'(tcw)};
  end

  // Sequencer
  logic fin_take;

  always_comb begin
    state_d  = state_q;
    go_d     = go_q;
    fin_take = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);
    if (unit_wait && !go_q) go_d = 1'b1;
    if (unit_done) go_d = 1'b0;
    case (state_q)
      S_IDLE: if (accept) state_d = entry_state;
      S_GCD1: if (gcd_stat.done) state_d = S_DIVP;
      S_DIVP: if (div_stat.done) state_d = S_DIVQ;
      S_DIVQ: if (div_stat.done) state_d = S_MUL0;
      S_MUL0: state_d = S_MUL1;
      S_MUL1: begin
        case (cmd_q)
          CMD_ADD, CMD_SUB: state_d = S_MUL2;
          CMD_CMP:          state_d = S_CMP;
          default:          state_d = S_RED;
        endcase
      end
      S_MUL2: state_d = S_SUM;
      S_SUM:  state_d = S_RED;
      S_CMP:  state_d = S_FIN;
      S_RED: begin
        if (!auto_reduce_q) state_d = S_FIN;
        else if (gcd_stat.done) state_d = S_DIVN;
      end
      S_DIVN: if (div_stat.done && div_den_q) state_d = S_FIN;
      S_FIN:  if (fin_take) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      go_q          <= 1'b0;
      auto_reduce_q <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      if (cfg_we_i) auto_reduce_q <= cfg_wdata_i;
      if (fin_take) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (fin_take) out_data_q <= fin_data;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q     <= in_cmd;
          an_q      <= m_an;
          ad_q      <= m_ad;
          bn_q      <= m_bn;
          bd_q      <= m_bd;
          sa_q      <= in_sa;
          sb_q      <= in_sb;
          zden_q    <= in_valid_cmd && in_zd;
          gt_q      <= 1'b0;
          lt_q      <= 1'b0;
          eq_q      <= 1'b0;
          div_den_q <= 1'b0;
          // Seed the working fraction for the short paths
          if (entry_state == S_SUM && a_one) begin
            den_q     <= MW'(m_bd);
            num_mag_q <= MW'(m_bd);
            num_neg_q <= 1'b0;
            tb_mag_q  <= MW'(m_bn);
            tb_neg_q  <= in_sb && (m_bn != '0);
          end else if (entry_state == S_SUM) begin
            den_q     <= MW'(m_ad);
            num_mag_q <= MW'(m_an);
            num_neg_q <= in_sa && (m_an != '0);
            tb_mag_q  <= MW'(m_ad);
            tb_neg_q  <= 1'b0;
          end else if (entry_state == S_RED) begin
            den_q     <= MW'(m_ad);
            num_mag_q <= MW'(m_an);
            num_neg_q <= !in_sa && (m_an != '0);
          end else begin
            den_q     <= (in_valid_cmd && in_zd) ? '0 : MW'(1);
            num_mag_q <= '0;
            num_neg_q <= 1'b0;
          end
        end
      end
      S_GCD1: if (gcd_stat.done) g_q <= gcd_g;
      S_DIVP: if (div_stat.done) p_q <= div_quo[WIDTH-1:0];
      S_DIVQ: if (div_stat.done) q_q <= div_quo[WIDTH-1:0];
      S_MUL0: den_q <= prod;
      S_MUL1: begin
        num_mag_q <= prod;
        num_neg_q <= mul1_sign && (prod != '0);
      end
      S_MUL2: begin
        tb_mag_q <= prod;
        tb_neg_q <= sb_q && (prod != '0);
      end
      S_SUM: begin
        num_mag_q <= sum_mag;
        num_neg_q <= sum_neg;
      end
      S_CMP: begin
        gt_q      <= c_gt;
        lt_q      <= c_lt;
        eq_q      <= c_eq;
        num_mag_q <= '0;
        num_neg_q <= 1'b0;
        den_q     <= MW'(1);
      end
      S_RED: if (gcd_stat.done) g_q <= gcd_g;
      S_DIVN: begin
        // Divide the numerator first, then the denominator
        if (div_stat.done) begin
          if (div_den_q) den_q <= div_quo;
          else num_mag_q <= div_quo;
          div_den_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  `RAU_ASSERT(a_flags_onehot, clk_i, rst_ni, m_axis_tvalid |-> $onehot0(m_axis_tdata[65:63]))
  `RAU_ASSERT(a_zero_clear, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[67:66] == ST_ZERO) |-> (m_axis_tdata[62:0] == 63'd0))
  `RAU_ASSERT(a_ok_den, clk_i, rst_ni, (m_axis_tvalid && m_axis_tdata[67:66] == ST_OK) |-> (m_axis_tdata[62:32] != 31'd0))
  `RAU_ASSERT(a_units_idle, clk_i, rst_ni, s_axis_tready |-> (!gcd_stat.busy && !div_stat.busy))
  `RAU_ASSERT_NR(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

// ===== design/rau_cell.sv =====
module rau_cell #(
  parameter int MW = 64
) (
  input  logic          clk_i,
  input  logic [MW-1:0] rem_i,
  input  logic [MW-1:0] quo_i,
  input  logic [MW-1:0] dvs_i,
  output logic [MW-1:0] rem_o,
  output logic [MW-1:0] quo_o
);
  import rau_pkg::*;

  logic [MW:0]   part;
  logic [MW:0]   diff;
  logic          ge;
  logic [MW-1:0] rem_d;
  logic [MW-1:0] quo_d;

  // One restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    part  = {rem_i, quo_i[MW-1]};
    diff  = part - {1'b0, dvs_i};
    ge    = (part >= {1'b0, dvs_i});
    rem_d = ge ? diff[MW-1:0] : part[MW-1:0];
    quo_d = {quo_i[MW-2:0], ge};
  end

  // Hand the partial word to the next cell
  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    quo_o <= quo_d;
  end

endmodule

// ===== design/rau_divider.sv =====
module rau_divider #(
  parameter int MW = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MW-1:0]       dvd_i,
  input  logic [MW-1:0]       dvs_i,
  output rau_pkg::unit_stat_t stat_o,
  output logic [MW-1:0]       quo_o
);
  import rau_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [MW-1:0] c0_rem_in, c0_quo_in, c0_dvs_in;
  logic [MW-1:0] c0_rem, c0_quo, c1_rem, c1_quo;

  // Load the ring on start, otherwise close it from the last cell
  always_comb begin
    c0_rem_in = start_i ? '0 : c1_rem;
    c0_quo_in = start_i ? dvd_i : c1_quo;
    c0_dvs_in = start_i ? dvs_i : dvs_q;
  end

  rau_cell #(.MW(MW)) u_cell0 (
    .clk_i (clk_i),
    .rem_i (c0_rem_in),
    .quo_i (c0_quo_in),
    .dvs_i (c0_dvs_in),
    .rem_o (c0_rem),
    .quo_o (c0_quo)
  );

  rau_cell #(.MW(MW)) u_cell1 (
    .clk_i (clk_i),
    .rem_i (c0_rem),
    .quo_i (c0_quo),
    .dvs_i (dvs_q),
    .rem_o (c1_rem),
    .quo_o (c1_quo)
  );

  // Hold the divisor for the whole pass
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= dvs_i;
    end
  end

  // Count steps; the word sits in the second cell after an even count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(1);
    end else if (busy_q) begin
      if (cnt_q == CW'(MW)) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (cnt_q == CW'(MW));
  assign quo_o       = c1_quo;

endmodule

// ===== design/rau_gcd.sv =====
module rau_gcd #(
  parameter int MW = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MW-1:0]       x_i,
  input  logic [MW-1:0]       y_i,
  output rau_pkg::unit_stat_t stat_o,
  output logic [MW-1:0]       g_o
);
  import rau_pkg::*;

  localparam int KW = $clog2(MW + 1);

  typedef enum logic [2:0] {
    G_IDLE  = 3'b001,
    G_RUN   = 3'b010,
    G_SHIFT = 3'b100
  } gstate_e;

  gstate_e       state_q, state_d;
  logic [MW-1:0] x_q, y_q;
  logic [KW-1:0] k_q;

  // Step the binary gcd until one side is zero, then restore common twos
  always_comb begin
    state_d = state_q;
    case (state_q)
      G_IDLE: begin
        if (start_i) state_d = G_RUN;
      end
      G_RUN: begin
        if (x_q == '0 || y_q == '0) state_d = G_SHIFT;
      end
      G_SHIFT: begin
        if (k_q == '0) state_d = G_IDLE;
      end
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == G_IDLE) begin
      x_q <= x_i;
      y_q <= y_i;
      k_q <= '0;
    end else if (state_q == G_RUN) begin
      if (x_q == '0) begin
        x_q <= y_q;
      end else if (y_q == '0) begin
        x_q <= x_q;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 1'b1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q >= y_q) begin
        x_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end else if (state_q == G_SHIFT && k_q != '0) begin
      x_q <= x_q << 1;
      k_q <= k_q - 1'b1;
    end
  end

  assign stat_o.busy = (state_q != G_IDLE);
  assign stat_o.done = (state_q == G_SHIFT) && (k_q == '0);
  assign g_o         = x_q;

endmodule

// ===== dv/rational_arithmetic_unit_checker.sv =====
module rational_arithmetic_unit_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [71:0]  m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o
);
  import rau_pkg::*;

  // Highest field first so the layout matches the result word
  typedef struct packed {
    logic [1:0]  status;
    logic        eq;
    logic        lt;
    logic        gt;
    logic [30:0] den;
    logic [31:0] num;
  } fraction_result_t;

  fraction_result_t result_q[$];
  logic             reduce_q;

  function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [63:0] magnitude(logic [31:0] v);
    return v[31] ? (64'd1 << 32) - {32'd0, v} : {32'd0, v};
  endfunction

  // Signed sum on sign/magnitude pairs
  function automatic void add_sm(input logic xn, input logic [63:0] xm, input logic yn,
                                 input logic [63:0] ym, output logic rn,
                                 output logic [63:0] rm);
    if (xn == yn) begin
      rn = xn;
      rm = xm + ym;
    end else if (xm >= ym) begin
      rn = xn;
      rm = xm - ym;
    end else begin
      rn = yn;
      rm = ym - xm;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic fraction_result_t compute_fraction(logic [2:0] cmd, logic [127:0] d,
                                                        logic reduce);
    fraction_result_t r;
    logic [31:0] an_r, ad_r, bn_r, bd_r;
    logic [63:0] an, ad, bn, bd, den, nm, ta, tb, lm, rm, g, lim, tc;
    logic        sa, sb, nn, tan, tbn, ln, rn, a_one, b_one;
    an_r = d[31:0];
    ad_r = d[63:32];
    bn_r = d[95:64];
    bd_r = d[127:96];
    an = magnitude(an_r);
    ad = magnitude(ad_r);
    bn = magnitude(bn_r);
    bd = magnitude(bd_r);
    sa = an_r[31] != ad_r[31];
    sb = bn_r[31] != bd_r[31];
    r = '0;
    r.den = 31'd1;
    den = 64'd1;
    nm = 0;
    nn = 1'b0;
    if (cmd > CMD_CMP) return r;
    if (ad == 0 || (cmd != CMD_NEG && bd == 0) || (cmd == CMD_DIV && bn == 0)) begin
      r.den = '0;
      r.status = ST_ZERO;
      return r;
    end
    case (cmd)
      CMD_ADD, CMD_SUB: begin
        a_one = an_r == ad_r;
        b_one = bn_r == bd_r;
        if (a_one) den = bd;
        else if (b_one) den = ad;
        else den = ad / gcd_u64(ad, bd) * bd;
        if (a_one) begin
          tan = 1'b0;
          ta = den;
        end else begin
          ta = an * (den / ad);
          tan = sa && ta != 0;
        end
        if (b_one && !a_one) begin
          tbn = 1'b0;
          tb = den;
        end else begin
          tb = bn * (den / bd);
          tbn = sb && tb != 0;
        end
        if (cmd == CMD_SUB) tbn = tb != 0 && !tbn;
        add_sm(tan, ta, tbn, tb, nn, nm);
      end
      CMD_MUL: begin
        nm = an * bn;
        den = ad * bd;
        nn = nm != 0 && sa != sb;
      end
      CMD_DIV: begin
        nm = an * bd;
        den = bn * ad;
        nn = nm != 0 && sa != sb;
      end
      CMD_NEG: begin
        nm = an;
        den = ad;
        nn = nm != 0 && !sa;
      end
      default: begin
        lm = an * bd;
        rm = bn * ad;
        ln = lm != 0 && sa;
        rn = rm != 0 && sb;
        if (ln != rn) begin
          r.gt = rn;
          r.lt = ln;
        end else if (lm == rm) r.eq = 1'b1;
        else if ((lm > rm) != ln) r.gt = 1'b1;
        else r.lt = 1'b1;
        return r;
      end
    endcase
    if (reduce) begin
      g = gcd_u64(nm, den);
      if (g != 0) begin
        nm = nm / g;
        den = den / g;
      end
    end
    lim = 64'd1 << 31;
    if ((nn ? nm > lim : nm >= lim) || den >= lim) r.status = ST_OVF;
    tc = nn ? -nm : nm;
    r.num = tc[31:0];
    r.den = den[30:0];
    return r;
  endfunction

  // Predict on accepted input, compare on accepted output
  always @(posedge clk_i or negedge rst_ni) begin
    fraction_result_t got, want;
    if (!rst_ni) begin
      reduce_q <= 1'b1;
      fail_count_o <= 0;
      result_q.delete();
    end else begin
      if (cfg_we_i) reduce_q <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(compute_fraction(s_axis_tuser, s_axis_tdata, reduce_q));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[67:0];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = result_q.pop_front();
          if (got !== want || m_axis_tdata[71:68] !== 4'd0) begin
            $display("%0t: expected num %h den %h g%b l%b e%b st %0d, got %h", $time,
                     want.num, want.den, want.gt, want.lt, want.eq, want.status,
                     m_axis_tdata);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = result_q.size();
endmodule

// ===== dv/rational_arithmetic_unit_tb.sv =====
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b1;
  logic         cfg_we_i = 1'b0;
  logic         cfg_wdata_i = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  logic         stim_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rational_arithmetic_unit #(.WIDTH(32)) DUT (.*);

  rational_arithmetic_unit_checker u_checker (
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .*
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one word and hold until accepted; valid stays up for a back-to-back word
  task automatic send_word(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {bd, bn, ad, an};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drain, then write the auto-reduce register while idle
  task automatic set_reduce(logic v);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (1400) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(1, 1000);
      2: return -$urandom_range(1, 1000);
      3: return $urandom_range(0, 65535) - 32768;
      4: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $urandom();
    endcase
  endfunction

  task automatic random_words(int n);
    logic [31:0] an, ad, bn, bd;
    logic [2:0]  cmd;
    repeat (n) begin
      cmd = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      an = rand_val();
      ad = rand_val();
      bn = rand_val();
      bd = rand_val();
      if ($urandom_range(0, 9) == 0) ad = an;
      if ($urandom_range(0, 9) == 0) bd = bn;
      if ($urandom_range(0, 19) != 0 && ad == 0) ad = 1;
      if ($urandom_range(0, 19) != 0 && bd == 0) bd = 7;
      send_word(cmd, an, ad, bn, bd);
    end
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    if ($urandom_range(0, 99) < 5) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(5, 30)) @(negedge clk_i);
    end else begin
      m_axis_tready <= $urandom_range(0, 2) != 0 || stim_done;
    end
  end

  // Watchdog on accepted words
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("rational_arithmetic_unit verification failed");
      $finish;
    end
  end

  initial begin
    #1 rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: every command, extremes, a or b equal to one, zero denominators
    send_word(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_word(CMD_SUB, 32'd5, 32'd5, 32'd2, 32'd7);
    send_word(CMD_ADD, 32'd5, 32'd5, -32'd2, -32'd7);
    send_word(CMD_SUB, 32'd3, 32'd4, 32'd9, 32'd9);
    send_word(CMD_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_word(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_word(CMD_DIV, 32'd3, -32'd4, -32'd6, 32'd8);
    send_word(CMD_DIV, 32'd3, 32'd4, 32'd0, 32'd8);
    send_word(CMD_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
    send_word(CMD_NEG, 32'd0, -32'd5, 32'd1, 32'd1);
    send_word(CMD_NEG, 32'd1, 32'd0, 32'd1, 32'd1);
    send_word(CMD_CMP, -32'd1, 32'd2, 32'd1, -32'd2);
    send_word(CMD_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
    send_word(CMD_CMP, 32'd1, -32'd2, 32'd1, 32'd3);
    send_word(CMD_CMP, 32'd0, 32'd5, 32'd0, -32'd3);
    send_word(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd0);
    send_word(CMD_SUB, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
    send_word(CMD_ADD, 32'd6, 32'd4, -32'd3, 32'd2);
    send_word(3'd6, 32'd1, 32'd2, 32'd3, 32'd4);
    send_word(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    set_reduce(1'b0);
    send_word(CMD_ADD, 32'd2, 32'd4, 32'd2, 32'd4);
    send_word(CMD_MUL, 32'd0, -32'd3, 32'd5, 32'd7);
    random_words(600);
    set_reduce(1'b1);
    random_words(700);
    set_reduce(1'b0);
    random_words(300);
    set_reduce(1'b1);
    random_words(300);
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (pending != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (fail_count == 0) $display("rational_arithmetic_unit verification clean");
    else $display("rational_arithmetic_unit verification failed");
    $finish;
  end
endmodule
